// ----- hw/rtl/largest_strong_component_size_assert.svh -----
// Assertion macros for the file that checks its own logic.
`ifndef LARGEST_STRONG_COMPONENT_SIZE_ASSERT_SVH
`define LARGEST_STRONG_COMPONENT_SIZE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define LSCS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lscs assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LSCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lscs assertion failed");

`endif

// ----- hw/rtl/lscs_pkg.sv -----
package lscs_pkg;
	localparam int CFG_W = 11;
	localparam int NODE_PORT_W = 10;
	localparam int OUT_W = 11;
	localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 11'd1024;
	localparam int MAX_NODES_DEF = 1024;
	localparam int MAX_EDGES_DEF = 4096;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_CLR,
		ST_CNT_RD,
		ST_CNT_OF,
		ST_CNT_WR,
		ST_PRE_RD,
		ST_PRE_WR,
		ST_FILL_RD,
		ST_FILL_OF,
		ST_FILL_WR,
		ST_SH_RD,
		ST_SH_WR,
		ST_SH_Z,
		ST_D_SEL,
		ST_D_CHK,
		ST_D_OF0,
		ST_D_OF1,
		ST_D_OF2,
		ST_D_STEP,
		ST_D_NB,
		ST_D_MK,
		ST_D_POP,
		ST_K_SEL,
		ST_K_U,
		ST_K_CHK,
		ST_K_OF0,
		ST_K_OF1,
		ST_K_OF2,
		ST_K_STEP,
		ST_K_NB,
		ST_K_MK,
		ST_K_POP,
		ST_DONE
	} state_t;
endpackage

// ----- hw/rtl/lscs_ram.sv -----
module lscs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- hw/rtl/largest_strong_component_size.sv -----
// Largest strong component of a directed graph.
// Edges arrive as words on the edge channel (edge_valid, edge_stall); a word
// is taken when edge_valid is high and edge_stall is low. Edges are taken one
// per cycle while the block is idle. The word with last_edge set starts the
// evaluation, and edge_stall stays high until the result has been loaded.
// The result channel (result_valid, result_stall) carries one word per graph:
// largest_size, component_count and bad_edge_seen. The result register holds
// while result_stall is high, and new edges are taken meanwhile.
// Evaluation builds forward and reverse adjacency in memory, runs the
// depth-first pass and then the labeling pass on the reverse graph. With n
// nodes and E stored edges its run time is set by the single read port of the
// offset, neighbor and mark memories.
// The node count register is written through cfg_valid, cfg_ready and
// cfg_data and must only change while the block is idle.
// Reset sets the node count to 1024, empties the edge buffer and drops any
// pending result. The per-graph offset and mark stores are cleared by a sweep
// at the start of every evaluation.
module largest_strong_component_size
	import lscs_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   edge_valid,
	output logic                   edge_stall,
	input  logic [NODE_PORT_W-1:0] edge_source,
	input  logic [NODE_PORT_W-1:0] edge_target,
	input  logic                   last_edge,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [OUT_W-1:0]       largest_size,
	output logic [OUT_W-1:0]       component_count,
	output logic                   bad_edge_seen,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data
);
	localparam int NW = $clog2(MAX_NODES);
	localparam int NCW = NW + 1;
	localparam int CW = (NCW > CFG_W) ? NCW : CFG_W;
	localparam int OW = $clog2(MAX_EDGES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int OAW = $clog2(MAX_NODES + 1);
	localparam int SW = NW + 2 * OW;

	state_t state_q, state_d;

	logic [CFG_W-1:0] ncfg_q;
	logic [OW-1:0]    held_q, e_q;
	logic             err_q;
	logic [NCW-1:0]   v_q, s_q, fin_q, sp_q, comps_q, size_q, best_q;
	logic [NW-1:0]    tn_q, nv_q, es_q, et_q;
	logic [OW-1:0]    tp_q, te_q, facc_q, racc_q;
	logic             rv_q;
	logic [OUT_W-1:0] largest_q, count_q;
	logic             bad_q;

	logic [CW-1:0]  cfg_w;
	logic [NCW-1:0] n_eff;
	logic           edge_acc, edge_bad, edge_keep, out_free;

	logic           edge_we;
	logic [NW-1:0]  esrc_rd, etgt_rd;
	logic           foff_we, roff_we;
	logic [OAW-1:0] foff_wa, roff_wa, foff_ra, roff_ra;
	logic [OW-1:0]  foff_wd, roff_wd, foff_rd, roff_rd;
	logic           fnb_we, rnb_we;
	logic [NW-1:0]  fnb_rd, rnb_rd;
	logic           mark_we, mark_wd, mark_rd;
	logic [NW-1:0]  mark_wa, mark_ra;
	logic           finm_we;
	logic [NW-1:0]  finm_rd;
	logic           stk_we;
	logic [SW-1:0]  stk_wd, stk_rd;

	always_comb begin
		cfg_w = CW'(ncfg_q);
		if (cfg_w == '0) begin
			cfg_w = CW'(1);
		end else if (cfg_w > CW'(MAX_NODES)) begin
			cfg_w = CW'(MAX_NODES);
		end
		n_eff = NCW'(cfg_w);
	end

	assign edge_stall = (state_q != ST_IDLE);
	assign edge_acc = edge_valid && !edge_stall;
	assign edge_bad = (CW'(edge_source) >= cfg_w) || (CW'(edge_target) >= cfg_w);
	assign edge_keep = !edge_bad && (held_q < OW'(MAX_EDGES));
	assign out_free = !rv_q || !result_stall;
	assign cfg_ready = 1'b1;
	assign result_valid = rv_q;
	assign largest_size = largest_q;
	assign component_count = count_q;
	assign bad_edge_seen = bad_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (edge_acc && last_edge) state_d = ST_CLR;
			end
			ST_CLR: begin
				if (v_q == n_eff) state_d = ST_CNT_RD;
			end
			ST_CNT_RD: state_d = (e_q == held_q) ? ST_PRE_RD : ST_CNT_OF;
			ST_CNT_OF: state_d = ST_CNT_WR;
			ST_CNT_WR: state_d = ST_CNT_RD;
			ST_PRE_RD: state_d = ST_PRE_WR;
			ST_PRE_WR: state_d = (v_q == n_eff) ? ST_FILL_RD : ST_PRE_RD;
			ST_FILL_RD: state_d = (e_q == held_q) ? ST_SH_RD : ST_FILL_OF;
			ST_FILL_OF: state_d = ST_FILL_WR;
			ST_FILL_WR: state_d = ST_FILL_RD;
			ST_SH_RD: state_d = ST_SH_WR;
			ST_SH_WR: state_d = (v_q == NCW'(1)) ? ST_SH_Z : ST_SH_RD;
			ST_SH_Z: state_d = ST_D_SEL;
			ST_D_SEL: state_d = (s_q == n_eff) ? ST_K_SEL : ST_D_CHK;
			ST_D_CHK: state_d = mark_rd ? ST_D_SEL : ST_D_OF0;
			ST_D_OF0: state_d = ST_D_OF1;
			ST_D_OF1: state_d = ST_D_OF2;
			ST_D_OF2: state_d = ST_D_STEP;
			ST_D_STEP: begin
				if (tp_q < te_q) state_d = ST_D_NB;
				else if (sp_q == '0) state_d = ST_D_SEL;
				else state_d = ST_D_POP;
			end
			ST_D_NB: state_d = ST_D_MK;
			ST_D_MK: state_d = mark_rd ? ST_D_STEP : ST_D_OF0;
			ST_D_POP: state_d = ST_D_STEP;
			ST_K_SEL: state_d = (fin_q == '0) ? ST_DONE : ST_K_U;
			ST_K_U: state_d = ST_K_CHK;
			ST_K_CHK: state_d = mark_rd ? ST_K_OF0 : ST_K_SEL;
			ST_K_OF0: state_d = ST_K_OF1;
			ST_K_OF1: state_d = ST_K_OF2;
			ST_K_OF2: state_d = ST_K_STEP;
			ST_K_STEP: begin
				if (tp_q < te_q) state_d = ST_K_NB;
				else if (sp_q == '0) state_d = ST_K_SEL;
				else state_d = ST_K_POP;
			end
			ST_K_NB: state_d = ST_K_MK;
			ST_K_MK: state_d = ST_K_STEP;
			ST_K_POP: state_d = ST_K_OF0;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		edge_we = edge_acc && edge_keep;
		foff_we = 1'b0;
		roff_we = 1'b0;
		foff_wa = '0;
		roff_wa = '0;
		foff_wd = '0;
		roff_wd = '0;
		foff_ra = '0;
		roff_ra = '0;
		fnb_we = 1'b0;
		rnb_we = 1'b0;
		mark_we = 1'b0;
		mark_wa = '0;
		mark_wd = 1'b0;
		mark_ra = '0;
		finm_we = 1'b0;
		stk_we = 1'b0;
		stk_wd = {tn_q, tp_q, te_q};
		case (state_q)
			ST_CLR: begin
				foff_we = 1'b1;
				roff_we = 1'b1;
				foff_wa = OAW'(v_q);
				roff_wa = OAW'(v_q);
				mark_we = 1'b1;
				mark_wa = v_q[NW-1:0];
			end
			ST_CNT_OF: begin
				foff_ra = OAW'({1'b0, esrc_rd} + NCW'(1));
				roff_ra = OAW'({1'b0, etgt_rd} + NCW'(1));
			end
			ST_CNT_WR: begin
				foff_we = 1'b1;
				roff_we = 1'b1;
				foff_wa = OAW'({1'b0, es_q} + NCW'(1));
				roff_wa = OAW'({1'b0, et_q} + NCW'(1));
				foff_wd = foff_rd + OW'(1);
				roff_wd = roff_rd + OW'(1);
			end
			ST_PRE_RD: begin
				foff_ra = OAW'(v_q);
				roff_ra = OAW'(v_q);
			end
			ST_PRE_WR: begin
				foff_we = 1'b1;
				roff_we = 1'b1;
				foff_wa = OAW'(v_q);
				roff_wa = OAW'(v_q);
				foff_wd = foff_rd + facc_q;
				roff_wd = roff_rd + racc_q;
			end
			ST_FILL_OF: begin
				foff_ra = OAW'(esrc_rd);
				roff_ra = OAW'(etgt_rd);
			end
			ST_FILL_WR: begin
				foff_we = 1'b1;
				roff_we = 1'b1;
				foff_wa = OAW'(es_q);
				roff_wa = OAW'(et_q);
				foff_wd = foff_rd + OW'(1);
				roff_wd = roff_rd + OW'(1);
				fnb_we = 1'b1;
				rnb_we = 1'b1;
			end
			ST_SH_RD: begin
				foff_ra = OAW'(v_q - NCW'(1));
				roff_ra = OAW'(v_q - NCW'(1));
			end
			ST_SH_WR: begin
				foff_we = 1'b1;
				roff_we = 1'b1;
				foff_wa = OAW'(v_q);
				roff_wa = OAW'(v_q);
				foff_wd = foff_rd;
				roff_wd = roff_rd;
			end
			ST_SH_Z: begin
				foff_we = 1'b1;
				roff_we = 1'b1;
			end
			ST_D_SEL: mark_ra = s_q[NW-1:0];
			ST_D_CHK: begin
				mark_we = !mark_rd;
				mark_wa = s_q[NW-1:0];
				mark_wd = 1'b1;
			end
			ST_D_OF0: foff_ra = OAW'(tn_q);
			ST_D_OF1: foff_ra = OAW'({1'b0, tn_q} + NCW'(1));
			ST_D_STEP: finm_we = !(tp_q < te_q);
			ST_D_NB: mark_ra = fnb_rd;
			ST_D_MK: begin
				mark_we = !mark_rd;
				mark_wa = nv_q;
				mark_wd = 1'b1;
				stk_we = !mark_rd;
			end
			ST_K_U: mark_ra = finm_rd;
			ST_K_CHK: begin
				mark_we = mark_rd;
				mark_wa = nv_q;
			end
			ST_K_OF0: roff_ra = OAW'(tn_q);
			ST_K_OF1: roff_ra = OAW'({1'b0, tn_q} + NCW'(1));
			ST_K_NB: mark_ra = rnb_rd;
			ST_K_MK: begin
				mark_we = mark_rd;
				mark_wa = nv_q;
				stk_we = mark_rd;
				stk_wd = {nv_q, {(2 * OW){1'b0}}};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ncfg_q <= NODE_COUNT_RESET;
			held_q <= '0;
			err_q <= 1'b0;
			rv_q <= 1'b0;
			e_q <= '0;
			v_q <= '0;
			s_q <= '0;
			fin_q <= '0;
			sp_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) ncfg_q <= cfg_data;
			if (rv_q && !result_stall && state_q != ST_DONE) rv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (edge_acc) begin
						if (edge_bad) err_q <= 1'b1;
						if (edge_keep) held_q <= held_q + OW'(1);
					end
					v_q <= '0;
				end
				ST_CLR: begin
					v_q <= v_q + NCW'(1);
					e_q <= '0;
				end
				ST_CNT_RD: begin
					v_q <= NCW'(1);
					facc_q <= '0;
					racc_q <= '0;
				end
				ST_CNT_OF, ST_FILL_OF: begin
					es_q <= esrc_rd;
					et_q <= etgt_rd;
				end
				ST_CNT_WR, ST_FILL_WR: e_q <= e_q + OW'(1);
				ST_PRE_WR: begin
					facc_q <= foff_rd + facc_q;
					racc_q <= roff_rd + racc_q;
					v_q <= v_q + NCW'(1);
					e_q <= '0;
				end
				ST_FILL_RD: v_q <= n_eff;
				ST_SH_WR: v_q <= v_q - NCW'(1);
				ST_SH_Z: begin
					s_q <= '0;
					fin_q <= '0;
					sp_q <= '0;
				end
				ST_D_SEL: begin
					comps_q <= '0;
					best_q <= '0;
				end
				ST_D_CHK: begin
					if (mark_rd) s_q <= s_q + NCW'(1);
					tn_q <= s_q[NW-1:0];
				end
				ST_D_OF1, ST_K_OF1: tp_q <= (state_q == ST_D_OF1) ? foff_rd : roff_rd;
				ST_D_OF2, ST_K_OF2: te_q <= (state_q == ST_D_OF2) ? foff_rd : roff_rd;
				ST_D_STEP: begin
					if (tp_q < te_q) begin
						tp_q <= tp_q + OW'(1);
					end else begin
						fin_q <= fin_q + NCW'(1);
						if (sp_q == '0) s_q <= s_q + NCW'(1);
						else sp_q <= sp_q - NCW'(1);
					end
				end
				ST_D_NB: nv_q <= fnb_rd;
				ST_D_MK: begin
					if (!mark_rd) begin
						sp_q <= sp_q + NCW'(1);
						tn_q <= nv_q;
					end
				end
				ST_D_POP: begin
					tn_q <= stk_rd[SW-1 -: NW];
					tp_q <= stk_rd[2*OW-1 -: OW];
					te_q <= stk_rd[OW-1:0];
				end
				ST_K_SEL: begin
					if (fin_q != '0) fin_q <= fin_q - NCW'(1);
				end
				ST_K_U: nv_q <= finm_rd;
				ST_K_CHK: begin
					comps_q <= comps_q + NCW'(mark_rd);
					size_q <= '0;
					tn_q <= nv_q;
				end
				ST_K_OF0: size_q <= size_q + NCW'(1);
				ST_K_STEP: begin
					if (tp_q < te_q) begin
						tp_q <= tp_q + OW'(1);
					end else if (sp_q == '0) begin
						if (size_q > best_q) best_q <= size_q;
					end else begin
						sp_q <= sp_q - NCW'(1);
					end
				end
				ST_K_NB: nv_q <= rnb_rd;
				ST_K_MK: begin
					if (mark_rd) sp_q <= sp_q + NCW'(1);
				end
				ST_K_POP: tn_q <= stk_rd[SW-1 -: NW];
				ST_DONE: begin
					if (out_free) begin
						rv_q <= 1'b1;
						largest_q <= OUT_W'(best_q);
						count_q <= OUT_W'(comps_q);
						bad_q <= err_q;
						err_q <= 1'b0;
						held_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	lscs_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_edge_src (
		.clk(clk), .we(edge_we), .waddr(held_q[EAW-1:0]), .wdata(NW'(edge_source)),
		.raddr(e_q[EAW-1:0]), .rdata(esrc_rd)
	);

	lscs_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_edge_tgt (
		.clk(clk), .we(edge_we), .waddr(held_q[EAW-1:0]), .wdata(NW'(edge_target)),
		.raddr(e_q[EAW-1:0]), .rdata(etgt_rd)
	);

	lscs_ram #(.WIDTH(OW), .DEPTH(MAX_NODES + 1)) u_foff (
		.clk(clk), .we(foff_we), .waddr(foff_wa), .wdata(foff_wd),
		.raddr(foff_ra), .rdata(foff_rd)
	);

	lscs_ram #(.WIDTH(OW), .DEPTH(MAX_NODES + 1)) u_roff (
		.clk(clk), .we(roff_we), .waddr(roff_wa), .wdata(roff_wd),
		.raddr(roff_ra), .rdata(roff_rd)
	);

	lscs_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_fnb (
		.clk(clk), .we(fnb_we), .waddr(foff_rd[EAW-1:0]), .wdata(et_q),
		.raddr(tp_q[EAW-1:0]), .rdata(fnb_rd)
	);

	lscs_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_rnb (
		.clk(clk), .we(rnb_we), .waddr(roff_rd[EAW-1:0]), .wdata(es_q),
		.raddr(tp_q[EAW-1:0]), .rdata(rnb_rd)
	);

	lscs_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark (
		.clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
		.raddr(mark_ra), .rdata(mark_rd)
	);

	lscs_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_finm (
		.clk(clk), .we(finm_we), .waddr(fin_q[NW-1:0]), .wdata(tn_q),
		.raddr(NW'(fin_q - NCW'(1))), .rdata(finm_rd)
	);

	lscs_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stk (
		.clk(clk), .we(stk_we), .waddr(sp_q[NW-1:0]), .wdata(stk_wd),
		.raddr(NW'(sp_q - NCW'(1))), .rdata(stk_rd)
	);

`include "largest_strong_component_size_assert.svh"

	`LSCS_ASSERT_NOW(a_idle_stack_empty, state_q == ST_IDLE, (sp_q == '0) && (fin_q == '0))
	`LSCS_ASSERT_NOW(a_held_bound, 1'b1, held_q <= OW'(MAX_EDGES))
	`LSCS_ASSERT_NEXT(a_label_end, (state_q == ST_K_SEL) && (fin_q == '0), state_q == ST_DONE)
endmodule

// ----- verif/tb.sv -----
module tb;
	import lscs_pkg::*;

	typedef struct {
		logic [NODE_PORT_W-1:0] src;
		logic [NODE_PORT_W-1:0] tgt;
		logic                   last;
	} edge_word_t;

	typedef struct {
		logic [OUT_W-1:0] largest;
		logic [OUT_W-1:0] count;
		logic             bad;
	} scc_result_t;

	localparam int NMAX = 1024;
	localparam int EMAX = 4096;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic edge_valid;
	logic edge_stall;
	logic [NODE_PORT_W-1:0] edge_source;
	logic [NODE_PORT_W-1:0] edge_target;
	logic last_edge;
	logic result_valid;
	logic result_stall;
	logic [OUT_W-1:0] largest_size;
	logic [OUT_W-1:0] component_count;
	logic bad_edge_seen;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	largest_strong_component_size dut (
		.clk(clk),
		.arst_n(arst_n),
		.edge_valid(edge_valid),
		.edge_stall(edge_stall),
		.edge_source(edge_source),
		.edge_target(edge_target),
		.last_edge(last_edge),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.largest_size(largest_size),
		.component_count(component_count),
		.bad_edge_seen(bad_edge_seen),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	edge_word_t pending_edges[$];
	scc_result_t expected_results[$];
	int unsigned node_setting;
	int unsigned held_src[$];
	int unsigned held_tgt[$];
	bit graph_bad;
	int errors;
	int edges_sent;
	int graphs_checked;
	int items_queued;
	bit edge_taken;
	bit no_idle;
	int hold_requests;
	int hold_served;
	int hold_left;
	int quiet_cycles;

	int unsigned fwd_off[NMAX+1];
	int unsigned rev_off[NMAX+1];
	int unsigned fwd_nb[EMAX];
	int unsigned rev_nb[EMAX];
	bit seen[NMAX];
	int unsigned label[NMAX];
	int unsigned finished[NMAX];
	int unsigned stk_node[NMAX];
	int unsigned stk_pos[NMAX];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned effective_nodes();
		if (node_setting == 0) return 1;
		if (node_setting > NMAX) return NMAX;
		return node_setting;
	endfunction

	task automatic build_lists(input int unsigned n, input bit reverse);
		int unsigned cnt[NMAX+1];
		int unsigned a;
		int unsigned b;
		for (int v = 0; v <= n; v++) cnt[v] = 0;
		for (int e = 0; e < held_src.size(); e++) begin
			a = reverse ? held_tgt[e] : held_src[e];
			cnt[a+1]++;
		end
		for (int v = 1; v <= n; v++) cnt[v] += cnt[v-1];
		for (int v = 0; v <= n; v++) begin
			if (reverse) rev_off[v] = cnt[v];
			else fwd_off[v] = cnt[v];
		end
		for (int e = 0; e < held_src.size(); e++) begin
			a = reverse ? held_tgt[e] : held_src[e];
			b = reverse ? held_src[e] : held_tgt[e];
			if (reverse) rev_nb[cnt[a]] = b;
			else fwd_nb[cnt[a]] = b;
			cnt[a]++;
		end
	endtask

	task automatic find_components(output scc_result_t res);
		int unsigned n;
		int unsigned fin;
		int unsigned sp;
		int unsigned comps;
		int unsigned best;
		int unsigned size;
		int unsigned u;
		int unsigned v;
		n = effective_nodes();
		fin = 0;
		comps = 0;
		best = 0;
		build_lists(n, 1'b0);
		build_lists(n, 1'b1);
		for (int s = 0; s < n; s++) begin
			seen[s] = 1'b0;
			label[s] = 0;
		end
		for (int s = 0; s < n; s++) begin
			if (!seen[s]) begin
				seen[s] = 1'b1;
				stk_node[0] = s;
				stk_pos[0] = fwd_off[s];
				sp = 1;
				while (sp > 0) begin
					u = stk_node[sp-1];
					if (stk_pos[sp-1] < fwd_off[u+1]) begin
						v = fwd_nb[stk_pos[sp-1]];
						stk_pos[sp-1]++;
						if (!seen[v] && sp < NMAX) begin
							seen[v] = 1'b1;
							stk_node[sp] = v;
							stk_pos[sp] = fwd_off[v];
							sp++;
						end
					end else begin
						if (fin < NMAX) begin
							finished[fin] = u;
							fin++;
						end
						sp--;
					end
				end
			end
		end
		while (fin > 0) begin
			fin--;
			u = finished[fin];
			if (label[u] == 0) begin
				comps++;
				label[u] = comps;
				size = 0;
				stk_node[0] = u;
				sp = 1;
				while (sp > 0) begin
					sp--;
					v = stk_node[sp];
					size++;
					for (int e = rev_off[v]; e < rev_off[v+1]; e++) begin
						if (label[rev_nb[e]] == 0 && sp < NMAX) begin
							label[rev_nb[e]] = comps;
							stk_node[sp] = rev_nb[e];
							sp++;
						end
					end
				end
				if (size > best) best = size;
			end
		end
		res.largest = best[OUT_W-1:0];
		res.count = comps[OUT_W-1:0];
		res.bad = graph_bad;
	endtask

	task automatic take_edge(input edge_word_t w);
		scc_result_t res;
		int unsigned n;
		n = effective_nodes();
		if (w.src >= n || w.tgt >= n) begin
			graph_bad = 1'b1;
		end else if (held_src.size() < EMAX) begin
			held_src.insert(held_src.size(), w.src);
			held_tgt.insert(held_tgt.size(), w.tgt);
		end
		if (w.last) begin
			find_components(res);
			expected_results.insert(expected_results.size(), res);
			held_src.delete();
			held_tgt.delete();
			graph_bad = 1'b0;
		end
	endtask

	task automatic report(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	always @(negedge clk) begin
		edge_word_t w;
		if (!arst_n) begin
			edge_valid <= 1'b0;
		end else if (!edge_valid || edge_taken) begin
			if (pending_edges.size() > 0 && (no_idle || $urandom_range(99) >= 11)) begin
				w = pending_edges.pop_front();
				edge_valid <= 1'b1;
				edge_source <= w.src;
				edge_target <= w.tgt;
				last_edge <= w.last;
			end else begin
				edge_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !no_idle && $urandom_range(99) < 11;
		end
	end

	always @(posedge clk) begin
		edge_word_t w;
		scc_result_t want;
		bit moved;
		moved = 1'b0;
		edge_taken = arst_n && edge_valid && !edge_stall;
		if (edge_taken) begin
			w.src = edge_source;
			w.tgt = edge_target;
			w.last = last_edge;
			take_edge(w);
			edges_sent++;
			moved = 1'b1;
		end
		if (arst_n && result_valid && !result_stall) begin
			moved = 1'b1;
			if (expected_results.size() == 0) begin
				$display("result word with nothing expected");
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (largest_size !== want.largest)
					report("largest_size", largest_size, want.largest);
				if (component_count !== want.count)
					report("component_count", component_count, want.count);
				if (bad_edge_seen !== want.bad)
					report("bad_edge_seen", bad_edge_seen, want.bad);
				graphs_checked++;
			end
		end
		if (cfg_valid && cfg_ready) moved = 1'b1;
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic write_nodes(input int unsigned value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		node_setting = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send(input int unsigned s, input int unsigned t, input bit last);
		edge_word_t w;
		w.src = s[NODE_PORT_W-1:0];
		w.tgt = t[NODE_PORT_W-1:0];
		w.last = last;
		pending_edges.insert(pending_edges.size(), w);
		items_queued++;
	endtask

	task automatic drain();
		while (pending_edges.size() > 0 || edge_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_graph(input int unsigned edges_max);
		int unsigned n;
		int unsigned k;
		int unsigned loop_len;
		n = effective_nodes();
		k = $urandom_range(edges_max, 1);
		if ($urandom_range(2) == 0) begin
			loop_len = $urandom_range(n, 1);
			for (int i = 0; i < loop_len && i < k - 1; i++)
				send(i, (i + 1) % loop_len, 1'b0);
		end
		for (int i = 0; i < k; i++) begin
			if ($urandom_range(99) < 8)
				send($urandom_range(1023), $urandom_range(1023), i == k - 1);
			else
				send($urandom_range(n - 1), $urandom_range(n - 1), i == k - 1);
		end
	endtask

	initial begin
		int unsigned choice;
		int unsigned graphs;
		arst_n = 1'b0;
		edge_valid = 1'b0;
		edge_source = '0;
		edge_target = '0;
		last_edge = 1'b0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		node_setting = NODE_COUNT_RESET;
		graph_bad = 1'b0;
		errors = 0;
		edges_sent = 0;
		graphs_checked = 0;
		items_queued = 0;
		edge_taken = 1'b0;
		no_idle = 1'b0;
		hold_requests = 0;
		hold_served = 0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(0, 1023, 1'b0);
		send(1023, 0, 1'b0);
		send(1023, 1023, 1'b0);
		send(5, 5, 1'b1);
		drain();
		write_nodes(4);
		hold_requests++;
		send(4, 0, 1'b0);
		send(1, 2, 1'b0);
		send(2, 1, 1'b0);
		send(3, 3, 1'b1);
		send(0, 1, 1'b0);
		send(1, 0, 1'b0);
		send(2, 3, 1'b0);
		send(3, 2, 1'b1);
		send(0, 7, 1'b1);
		drain();
		write_nodes(0);
		send(0, 0, 1'b1);
		send(1, 0, 1'b1);
		drain();
		write_nodes(2047);
		send(1023, 1022, 1'b0);
		send(1022, 1023, 1'b1);
		drain();
		write_nodes(1);
		send(0, 0, 1'b1);
		drain();

		while (items_queued < 1450) begin
			choice = $urandom_range(99);
			if (choice < 6) write_nodes(1024);
			else if (choice < 8) write_nodes($urandom_range(2047, 1025));
			else if (choice < 10) write_nodes(0);
			else if (choice < 20) write_nodes($urandom_range(100, 25));
			else write_nodes($urandom_range(24, 1));
			no_idle = $urandom_range(9) == 0;
			if (node_setting >= 25 || node_setting == 0) begin
				random_graph(40);
			end else begin
				graphs = $urandom_range(6, 1);
				if ($urandom_range(7) == 0) hold_requests++;
				for (int g = 0; g < graphs; g++)
					random_graph(3 * node_setting + 2);
			end
			drain();
		end
		no_idle = 1'b0;
		drain();
		repeat (100) @(posedge clk);
		$display("%0d edge words sent, %0d graph results checked over node counts 0 to 2047",
			edges_sent, graphs_checked);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
